### hdl/blm_pkg.sv
// shared types and constants of the buffer frame lru manager
// used by blm_cell and buffer_frame_lru_manager_top
package blm_pkg;

  localparam int FRAMES = 16;
  localparam int FILE_ID_BITS = 8;
  localparam int BLOCK_TAG_BITS = 20;
  localparam int IDX_W = $clog2(FRAMES);
  localparam int FRAME_BITS = 4;
  localparam int CMD_BITS = 3;

  localparam int IN_W = FILE_ID_BITS + BLOCK_TAG_BITS + 3;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W = FRAME_BITS + 3 + FILE_ID_BITS + BLOCK_TAG_BITS;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [FILE_ID_BITS-1:0] file_t;
  typedef logic [BLOCK_TAG_BITS-1:0] block_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ACCESS = 3'd0,
    CMD_ALLOC  = 3'd1,
    CMD_PIN    = 3'd2,
    CMD_UNPIN  = 3'd3,
    CMD_INVAL  = 3'd4,
    CMD_RESET  = 3'd5,
    CMD_FLUSH  = 3'd6,
    CMD_NOP    = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_LOAD,
    UPD_HIT,
    UPD_INVAL,
    UPD_CLEAR
  } upd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic hit_f;
    idx_t hit_i;
    idx_t hit_r;
    logic inv_f;
    idx_t inv_i;
    idx_t inv_r;
    logic p0_f;
    idx_t p0_i;
    idx_t p0_r;
    logic p1_f;
    idx_t p1_i;
    idx_t p1_r;
    logic p2_f;
    idx_t p2_i;
    idx_t p2_r;
  } scan_t;

  typedef struct packed {
    upd_e   op;
    idx_t   idx;
    idx_t   rank;
    logic   touch;
    logic   dirty;
    logic   pinned;
    logic   pin_we;
    file_t  file;
    block_t block;
  } upd_t;

  typedef struct packed {
    logic   valid;
    logic   dirty;
    logic   pinned;
    file_t  file;
    block_t block;
  } view_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic   hit;
    logic   wb;
    file_t  wb_file;
    block_t wb_block;
    logic   all_pinned;
    logic   last;
  } res_t;

endpackage

### hdl/blm_cell.sv
// one directory cell: tags, flags and age rank of a single frame
// passes the registered search record to its neighbor; uses blm_pkg
module blm_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  blm_pkg::idx_t   cell_idx_i,
  input  blm_pkg::file_t  fid_i,
  input  blm_pkg::block_t blk_i,
  input  blm_pkg::scan_t  scan_i,
  output blm_pkg::scan_t  scan_o,
  input  blm_pkg::upd_t   upd_i,
  output blm_pkg::view_t  view_o
);

  blm_pkg::file_t  file_q;
  blm_pkg::block_t block_q;
  logic            valid_q, valid_d;
  logic            dirty_q, dirty_d;
  logic            pinned_q, pinned_d;
  blm_pkg::idx_t   rank_q, rank_d;
  blm_pkg::scan_t  scan_q, scan_d;
  logic            me;
  logic            hit_ok;

  assign me = (upd_i.idx == cell_idx_i);
  assign hit_ok = valid_q && (file_q == fid_i) && (block_q == blk_i);

  always_comb begin
    scan_d = scan_i;
    if (!scan_i.hit_f && hit_ok) begin
      scan_d.hit_f = 1'b1;
      scan_d.hit_i = cell_idx_i;
      scan_d.hit_r = rank_q;
    end
    if (!scan_i.inv_f && !valid_q) begin
      scan_d.inv_f = 1'b1;
      scan_d.inv_i = cell_idx_i;
      scan_d.inv_r = rank_q;
    end
    if (!pinned_q && (file_q != fid_i) && (!scan_i.p0_f || rank_q > scan_i.p0_r)) begin
      scan_d.p0_f = 1'b1;
      scan_d.p0_i = cell_idx_i;
      scan_d.p0_r = rank_q;
    end
    if (!pinned_q && (!scan_i.p1_f || rank_q > scan_i.p1_r)) begin
      scan_d.p1_f = 1'b1;
      scan_d.p1_i = cell_idx_i;
      scan_d.p1_r = rank_q;
    end
    if (!scan_i.p2_f || rank_q > scan_i.p2_r) begin
      scan_d.p2_f = 1'b1;
      scan_d.p2_i = cell_idx_i;
      scan_d.p2_r = rank_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    pinned_d = pinned_q;
    rank_d = rank_q;
    case (upd_i.op)
      blm_pkg::UPD_LOAD: begin
        if (me) begin
          valid_d = 1'b1;
          dirty_d = upd_i.dirty;
          pinned_d = upd_i.pinned;
          rank_d = '0;
        end else if (rank_q < upd_i.rank) begin
          rank_d = rank_q + 1'b1;
        end
      end
      blm_pkg::UPD_HIT: begin
        if (me) begin
          dirty_d = dirty_q | upd_i.dirty;
          if (upd_i.pin_we) begin
            pinned_d = upd_i.pinned;
          end
        end
        if (upd_i.touch) begin
          if (me) begin
            rank_d = '0;
          end else if (rank_q < upd_i.rank) begin
            rank_d = rank_q + 1'b1;
          end
        end
      end
      blm_pkg::UPD_INVAL: begin
        if (file_q == upd_i.file) begin
          valid_d = 1'b0;
        end
      end
      blm_pkg::UPD_CLEAR: begin
        valid_d = 1'b0;
        dirty_d = 1'b0;
        pinned_d = 1'b0;
        rank_d = cell_idx_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      pinned_q <= 1'b0;
      rank_q <= cell_idx_i;
      scan_q <= '0;
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      pinned_q <= pinned_d;
      rank_q <= rank_d;
      scan_q <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.op == blm_pkg::UPD_LOAD && me) begin
      file_q <= upd_i.file;
      block_q <= upd_i.block;
    end
  end

  assign scan_o = scan_q;
  assign view_o = '{valid: valid_q, dirty: dirty_q, pinned: pinned_q,
                    file: file_q, block: block_q};

endmodule

### hdl/buffer_frame_lru_manager_top.sv
// Buffer frame directory with lru replacement and pinning. One item is taken at a time.
// Every command that searches the directory (access, allocate, pin, unpin) walks its search
// record through the chain of frame cells, one cell per cycle, and then hands off its result.
// Invalidate, reset and unused commands go straight to the apply state. A flush gives
// FRAMES results, one per cycle while the output is taken. Results sit in an output
// register, so the block frees its input once that register is loaded.
module buffer_frame_lru_manager_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // file_id, block_number, write_access, touch_on_hit, pin_on_load
  input  logic [blm_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // command
  input  logic [blm_pkg::CMD_BITS-1:0]       s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // frame, hit, writeback, writeback_file, writeback_block, all_pinned
  output logic [blm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);

  localparam int FB = blm_pkg::FILE_ID_BITS;
  localparam int BB = blm_pkg::BLOCK_TAG_BITS;

  blm_pkg::state_e st_q, st_d;
  blm_pkg::cmd_e   cmd_q;
  blm_pkg::file_t  fid_q;
  blm_pkg::block_t blk_q;
  logic            wr_q, touch_q, pin_q;
  blm_pkg::idx_t   cnt_q, cnt_d;
  logic            out_valid_q;
  blm_pkg::res_t   res_q, res_d;
  logic            load_res;
  logic            slot_free;
  logic            in_acc;
  blm_pkg::upd_t   upd;
  blm_pkg::scan_t  chain_in [blm_pkg::FRAMES];
  blm_pkg::scan_t  chain_out [blm_pkg::FRAMES];
  blm_pkg::view_t  views [blm_pkg::FRAMES];
  blm_pkg::scan_t  fin;
  blm_pkg::idx_t   vic;
  blm_pkg::idx_t   vic_r;
  logic            vic_ap;
  blm_pkg::view_t  vv;
  blm_pkg::view_t  fv;

  for (genvar g = 0; g < blm_pkg::FRAMES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign chain_in[g] = '0;
    end else begin : g_link
      assign chain_in[g] = chain_out[g-1];
    end
    blm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (blm_pkg::IDX_W'(g)),
      .fid_i      (fid_q),
      .blk_i      (blk_q),
      .scan_i     (chain_in[g]),
      .scan_o     (chain_out[g]),
      .upd_i      (upd),
      .view_o     (views[g])
    );
  end

  assign fin = chain_out[blm_pkg::FRAMES-1];
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (st_q == blm_pkg::ST_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    vic_ap = 1'b0;
    if (fin.inv_f) begin
      vic = fin.inv_i;
      vic_r = fin.inv_r;
    end else if (fin.p0_f) begin
      vic = fin.p0_i;
      vic_r = fin.p0_r;
    end else if (fin.p1_f) begin
      vic = fin.p1_i;
      vic_r = fin.p1_r;
    end else begin
      vic = fin.p2_i;
      vic_r = fin.p2_r;
      vic_ap = 1'b1;
    end
  end

  assign vv = views[vic];
  assign fv = views[cnt_q];

  // next state
  always_comb begin
    st_d = st_q;
    cnt_d = cnt_q;
    case (st_q)
      blm_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_acc) begin
          case (blm_pkg::cmd_e'(s_axis_tuser_i))
            blm_pkg::CMD_ACCESS, blm_pkg::CMD_ALLOC,
            blm_pkg::CMD_PIN, blm_pkg::CMD_UNPIN: st_d = blm_pkg::ST_SCAN;
            blm_pkg::CMD_FLUSH: st_d = blm_pkg::ST_FLUSH;
            default: st_d = blm_pkg::ST_APPLY;
          endcase
        end
      end
      blm_pkg::ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == blm_pkg::IDX_W'(blm_pkg::FRAMES - 1)) begin
          st_d = blm_pkg::ST_APPLY;
        end
      end
      blm_pkg::ST_APPLY: begin
        if (slot_free) begin
          st_d = blm_pkg::ST_IDLE;
        end
      end
      blm_pkg::ST_FLUSH: begin
        if (slot_free) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == blm_pkg::IDX_W'(blm_pkg::FRAMES - 1)) begin
            st_d = blm_pkg::ST_IDLE;
          end
        end
      end
      default: st_d = blm_pkg::ST_IDLE;
    endcase
  end

  // outputs and directory updates
  always_comb begin
    upd = '{op: blm_pkg::UPD_NONE, idx: vic, rank: vic_r, touch: 1'b0, dirty: 1'b0,
            pinned: 1'b0, pin_we: 1'b0, file: fid_q, block: blk_q};
    res_d = '0;
    res_d.last = 1'b1;
    load_res = 1'b0;
    case (st_q)
      blm_pkg::ST_APPLY: begin
        load_res = slot_free;
        case (cmd_q)
          blm_pkg::CMD_ACCESS, blm_pkg::CMD_ALLOC, blm_pkg::CMD_PIN: begin
            if (fin.hit_f && cmd_q != blm_pkg::CMD_ALLOC) begin
              upd.op = blm_pkg::UPD_HIT;
              upd.idx = fin.hit_i;
              upd.rank = fin.hit_r;
              upd.touch = (cmd_q == blm_pkg::CMD_ACCESS) && touch_q;
              upd.dirty = (cmd_q == blm_pkg::CMD_ACCESS) && wr_q;
              upd.pin_we = (cmd_q == blm_pkg::CMD_PIN);
              upd.pinned = 1'b1;
              res_d.frame = blm_pkg::FRAME_BITS'(fin.hit_i);
              res_d.hit = 1'b1;
            end else begin
              upd.op = blm_pkg::UPD_LOAD;
              upd.dirty = (cmd_q == blm_pkg::CMD_ALLOC) ||
                          ((cmd_q == blm_pkg::CMD_ACCESS) && wr_q);
              upd.pinned = (cmd_q == blm_pkg::CMD_PIN) ||
                           ((cmd_q == blm_pkg::CMD_ALLOC) && pin_q);
              res_d.frame = blm_pkg::FRAME_BITS'(vic);
              res_d.wb = vv.valid && vv.dirty;
              res_d.wb_file = (vv.valid && vv.dirty) ? vv.file : '0;
              res_d.wb_block = (vv.valid && vv.dirty) ? vv.block : '0;
              res_d.all_pinned = vic_ap;
            end
          end
          blm_pkg::CMD_UNPIN: begin
            if (fin.hit_f) begin
              upd.op = blm_pkg::UPD_HIT;
              upd.idx = fin.hit_i;
              upd.pin_we = 1'b1;
              upd.pinned = 1'b0;
              res_d.frame = blm_pkg::FRAME_BITS'(fin.hit_i);
              res_d.hit = 1'b1;
            end
          end
          blm_pkg::CMD_INVAL: upd.op = blm_pkg::UPD_INVAL;
          blm_pkg::CMD_RESET: upd.op = blm_pkg::UPD_CLEAR;
          default: begin
          end
        endcase
        if (!slot_free) begin
          upd.op = blm_pkg::UPD_NONE;
        end
      end
      blm_pkg::ST_FLUSH: begin
        load_res = slot_free;
        res_d.frame = blm_pkg::FRAME_BITS'(cnt_q);
        res_d.wb = fv.valid && fv.dirty;
        res_d.wb_file = (fv.valid && fv.dirty) ? fv.file : '0;
        res_d.wb_block = (fv.valid && fv.dirty) ? fv.block : '0;
        res_d.last = (cnt_q == blm_pkg::IDX_W'(blm_pkg::FRAMES - 1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= blm_pkg::ST_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= blm_pkg::cmd_e'(s_axis_tuser_i);
      fid_q <= s_axis_tdata_i[FB-1:0];
      blk_q <= s_axis_tdata_i[FB+BB-1:FB];
      wr_q <= s_axis_tdata_i[FB+BB];
      touch_q <= s_axis_tdata_i[FB+BB+1];
      pin_q <= s_axis_tdata_i[FB+BB+2];
    end
    if (load_res) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o = res_q.last;
  assign m_axis_tdata_o = blm_pkg::OUT_TDATA_W'({res_q.all_pinned, res_q.wb_block,
                                                 res_q.wb_file, res_q.wb, res_q.hit,
                                                 res_q.frame});

`ifndef SYNTHESIS
  a_upd_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd.op != blm_pkg::UPD_NONE) |-> load_res)
    else $error("directory changed without a result");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("input taken while an item is in progress");
  a_flush_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == blm_pkg::ST_FLUSH && load_res && res_d.last) |=> (st_q == blm_pkg::ST_IDLE))
    else $error("flush did not end after its last frame");
`endif

endmodule

### test/buffer_frame_lru_manager_top_tb.sv
// testbench for buffer_frame_lru_manager_top: random and directed commands against a
// behavioral directory model, results checked in order; depends on blm_pkg
`timescale 1ns / 1ps
module buffer_frame_lru_manager_top_tb;

  typedef struct {
    blm_pkg::cmd_e   cmd;
    blm_pkg::file_t  fid;
    blm_pkg::block_t blk;
    logic            wr;
    logic            touch;
    logic            pin_new;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0]      frame;
    logic            hit;
    logic            wb;
    blm_pkg::file_t  wb_file;
    blm_pkg::block_t wb_block;
    logic            all_pinned;
    logic            last;
  } frame_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [blm_pkg::IN_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic [blm_pkg::CMD_BITS-1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [blm_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic m_axis_tlast_o;

  buffer_frame_lru_manager_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o),
    .m_axis_tlast_o(m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // directory copy
  blm_pkg::file_t  dir_file [blm_pkg::FRAMES];
  blm_pkg::block_t dir_block [blm_pkg::FRAMES];
  logic            dir_valid [blm_pkg::FRAMES];
  logic            dir_dirty [blm_pkg::FRAMES];
  logic            dir_pinned [blm_pkg::FRAMES];
  int              dir_age [blm_pkg::FRAMES];

  cmd_item_t  pending_cmds [$];
  frame_res_t expected_res [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 0;
  int quiet_cycles = 0;

  // handshake seen at the rising edge, used by the driver on the next falling edge
  logic s_axis_tready_o_q = 1'b0;
  always @(posedge clk_i) s_axis_tready_o_q <= s_axis_tready_o;

  function automatic void clear_dir();
    for (int i = 0; i < blm_pkg::FRAMES; i++) begin
      dir_valid[i] = 0;
      dir_dirty[i] = 0;
      dir_pinned[i] = 0;
      dir_age[i] = i;
    end
  endfunction

  function automatic void promote(int f);
    int r;
    r = dir_age[f];
    for (int i = 0; i < blm_pkg::FRAMES; i++)
      if (dir_age[i] < r) dir_age[i]++;
    dir_age[f] = 0;
  endfunction

  function automatic int lookup(blm_pkg::file_t fid, blm_pkg::block_t blk);
    for (int i = 0; i < blm_pkg::FRAMES; i++)
      if (dir_valid[i] && dir_file[i] == fid && dir_block[i] == blk) return i;
    return -1;
  endfunction

  function automatic frame_res_t load_victim(blm_pkg::file_t fid, blm_pkg::block_t blk,
                                             logic d, logic p);
    frame_res_t r;
    int v;
    v = -1;
    r = '0;
    r.last = 1;
    for (int i = 0; i < blm_pkg::FRAMES && v < 0; i++)
      if (!dir_valid[i]) v = i;
    for (int pass = 0; pass < 3 && v < 0; pass++) begin
      for (int i = 0; i < blm_pkg::FRAMES; i++) begin
        if (pass < 2 && dir_pinned[i]) continue;
        if (pass == 0 && dir_file[i] == fid) continue;
        if (v < 0 || dir_age[i] > dir_age[v]) v = i;
      end
      if (pass == 2) r.all_pinned = 1;
    end
    r.frame = 4'(v);
    if (dir_valid[v] && dir_dirty[v]) begin
      r.wb = 1;
      r.wb_file = dir_file[v];
      r.wb_block = dir_block[v];
    end
    dir_file[v] = fid;
    dir_block[v] = blk;
    dir_valid[v] = 1;
    dir_dirty[v] = d;
    dir_pinned[v] = p;
    promote(v);
    return r;
  endfunction

  function automatic void predict_directory(cmd_item_t c);
    frame_res_t r;
    int f;
    r = '0;
    r.last = 1;
    f = lookup(c.fid, c.blk);
    case (c.cmd)
      blm_pkg::CMD_ACCESS: begin
        if (f >= 0) begin
          if (c.wr) dir_dirty[f] = 1;
          if (c.touch) promote(f);
          r.frame = 4'(f);
          r.hit = 1;
        end else r = load_victim(c.fid, c.blk, c.wr, 1'b0);
      end
      blm_pkg::CMD_ALLOC: r = load_victim(c.fid, c.blk, 1'b1, c.pin_new);
      blm_pkg::CMD_PIN: begin
        if (f >= 0) begin
          dir_pinned[f] = 1;
          r.frame = 4'(f);
          r.hit = 1;
        end else r = load_victim(c.fid, c.blk, 1'b0, 1'b1);
      end
      blm_pkg::CMD_UNPIN: begin
        if (f >= 0) begin
          dir_pinned[f] = 0;
          r.frame = 4'(f);
          r.hit = 1;
        end
      end
      blm_pkg::CMD_INVAL: begin
        for (int i = 0; i < blm_pkg::FRAMES; i++)
          if (dir_file[i] == c.fid) dir_valid[i] = 0;
      end
      blm_pkg::CMD_RESET: clear_dir();
      blm_pkg::CMD_FLUSH: begin
        for (int i = 0; i < blm_pkg::FRAMES; i++) begin
          r = '0;
          r.frame = 4'(i);
          if (dir_valid[i] && dir_dirty[i]) begin
            r.wb = 1;
            r.wb_file = dir_file[i];
            r.wb_block = dir_block[i];
          end
          r.last = (i == blm_pkg::FRAMES - 1);
          expected_res.insert(expected_res.size(), r);
        end
        return;
      end
      default: ;
    endcase
    expected_res.insert(expected_res.size(), r);
  endfunction

  // file tags written only into frames that are valid afterwards, so any
  // invalidate touches only written entries once every frame was loaded
  function automatic void queue_cmd(blm_pkg::cmd_e cmd, blm_pkg::file_t fid,
                                    blm_pkg::block_t blk, logic wr, logic touch,
                                    logic pin_new);
    cmd_item_t c;
    c.cmd = cmd;
    c.fid = fid;
    c.blk = blk;
    c.wr = wr;
    c.touch = touch;
    c.pin_new = pin_new;
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic logic rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic blm_pkg::block_t pick_block();
    return ($urandom_range(0, 9) == 0) ? blm_pkg::block_t'($urandom) :
                                         blm_pkg::block_t'($urandom_range(0, 5));
  endfunction

  function automatic blm_pkg::file_t pick_file();
    return ($urandom_range(0, 9) == 0) ? blm_pkg::file_t'($urandom) :
                                         blm_pkg::file_t'($urandom_range(0, 3));
  endfunction

  // driver
  always @(negedge clk_i) begin
    cmd_item_t c;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o_q) begin
        predict_directory(pending_cmds.pop_front());
      end
      if ((!s_axis_tvalid_i || s_axis_tready_o_q) && pending_cmds.size() > 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        c = pending_cmds[0];
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i <= c.cmd;
        s_axis_tdata_i <= blm_pkg::IN_TDATA_W'({c.pin_new, c.touch, c.wr, c.blk, c.fid});
      end else if (!s_axis_tvalid_i || s_axis_tready_o_q) begin
        s_axis_tvalid_i <= 1'b0;
      end
      m_axis_tready_i <= !hold_recv && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    frame_res_t got, exp_r;
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.frame = m_axis_tdata_o[3:0];
        got.hit = m_axis_tdata_o[4];
        got.wb = m_axis_tdata_o[5];
        got.wb_file = m_axis_tdata_o[13:6];
        got.wb_block = m_axis_tdata_o[33:14];
        got.all_pinned = m_axis_tdata_o[34];
        got.last = m_axis_tlast_o;
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          exp_r = expected_res.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
            errors++;
          end
        end
      end
      if (quiet_cycles > 20000) begin
        $display("buffer_frame_lru_manager_top regression: fail");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || s_axis_tvalid_i || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    int k;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (k = 0; k < count; k++) begin
      int sel;
      blm_pkg::cmd_e cmd;
      blm_pkg::file_t fid;
      blm_pkg::block_t blk;
      logic pin_new;
      sel = $urandom_range(0, 99);
      pin_new = rbit();
      if (sel < 35) cmd = blm_pkg::CMD_ACCESS;
      else if (sel < 50) begin
        cmd = blm_pkg::CMD_ALLOC;
        pin_new = ($urandom_range(0, 3) == 0);
      end
      else if (sel < 65) cmd = blm_pkg::CMD_PIN;
      else if (sel < 85) cmd = blm_pkg::CMD_UNPIN;
      else if (sel < 90) cmd = blm_pkg::CMD_INVAL;
      else if (sel < 93) cmd = blm_pkg::CMD_RESET;
      else if (sel < 96) cmd = blm_pkg::CMD_FLUSH;
      else cmd = blm_pkg::CMD_NOP;
      fid = (sel < 90) ? pick_file() : blm_pkg::file_t'($urandom);
      blk = (sel < 85) ? pick_block() : blm_pkg::block_t'($urandom);
      queue_cmd(cmd, fid, blk, rbit(), rbit(), pin_new);
    end
    wait_drained();
  endtask

  initial begin
    clear_dir();
    for (int i = 0; i < blm_pkg::FRAMES; i++) begin
      dir_file[i] = '0;
      dir_block[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill every frame first so later invalidates only see written tags
    for (int i = 0; i < blm_pkg::FRAMES; i++)
      queue_cmd(blm_pkg::CMD_ALLOC, blm_pkg::file_t'(i % 3), blm_pkg::block_t'(i),
                1'b0, 1'b0, 1'b0);
    queue_cmd(blm_pkg::CMD_ACCESS, 8'hff, 20'hfffff, 1'b1, 1'b1, 1'b1);
    queue_cmd(blm_pkg::CMD_ACCESS, 8'hff, 20'hfffff, 1'b0, 1'b1, 1'b0);
    queue_cmd(blm_pkg::CMD_PIN, 8'h00, 20'h00000, 1'b0, 1'b0, 1'b0);
    queue_cmd(blm_pkg::CMD_UNPIN, 8'h00, 20'h00000, 1'b0, 1'b0, 1'b0);
    queue_cmd(blm_pkg::CMD_UNPIN, 8'h55, 20'h12345, 1'b0, 1'b0, 1'b0);
    queue_cmd(blm_pkg::CMD_FLUSH, 8'h00, 20'h0, 1'b0, 1'b0, 1'b0);
    queue_cmd(blm_pkg::CMD_INVAL, 8'h01, 20'h0, 1'b0, 1'b0, 1'b0);
    queue_cmd(blm_pkg::CMD_NOP, 8'hff, 20'hfffff, 1'b1, 1'b1, 1'b1);
    queue_cmd(blm_pkg::CMD_RESET, 8'h00, 20'h0, 1'b0, 1'b0, 1'b0);
    // all frames pinned, then one more allocate
    for (int i = 0; i < blm_pkg::FRAMES; i++)
      queue_cmd(blm_pkg::CMD_ALLOC, 8'h07, blm_pkg::block_t'(i), 1'b0, 1'b0, 1'b1);
    queue_cmd(blm_pkg::CMD_ALLOC, 8'h07, 20'h00abc, 1'b0, 1'b0, 1'b1);
    queue_cmd(blm_pkg::CMD_FLUSH, 8'h00, 20'h0, 1'b0, 1'b0, 1'b0);
    wait_drained();

    run_phase(0, 0, 50);
    run_phase(74, 0, 45);
    run_phase(0, 74, 45);
    run_phase(14, 14, 35);

    // long receiver hold while the sender keeps offering
    hold_recv = 1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 12; i++)
      queue_cmd(blm_pkg::CMD_ACCESS, pick_file(), pick_block(), rbit(), rbit(), 1'b0);
    repeat (300) @(posedge clk_i);
    hold_recv = 0;
    wait_drained();

    if (errors == 0 && expected_res.size() == 0) begin
      $display("buffer_frame_lru_manager_top regression: pass");
    end else begin
      $display("buffer_frame_lru_manager_top regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
hdl/blm_pkg.sv
hdl/blm_cell.sv
hdl/buffer_frame_lru_manager_top.sv
test/buffer_frame_lru_manager_top_tb.sv
